// File: rtl/hcbd_pkg.sv
// Package with types, constants and helper functions of the chunked body decoder.
`default_nettype none
package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] MAX_LEN_RESET = 8'd32;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEADER,
    PH_BODY,
    PH_CR,
    PH_LF,
    PH_CR_END,
    PH_LF_END,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_NOT_STARTED,
    ERR_LINE_LONG,
    ERR_OVERFLOW,
    ERR_NO_CR_DATA,
    ERR_NO_LF_DATA,
    ERR_NO_CR_END,
    ERR_NO_LF_END
  } err_t;

  typedef struct packed {
    phase_t                 phase;
    logic [SIZE_BITS-1:0]   chunk_remaining;
    logic [7:0]             line_count;
    logic                   digits_ended;
    logic                   pending_cr;
    err_t                   sticky_error;
  } state_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       consumed;
    logic       done_res;
    err_t       error_code;
  } result_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] chunk_remaining;
    logic [7:0]           line_count;
    logic                 digits_ended;
    err_t                 err;
  } line_upd_t;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) v = {1'b0, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) v = {1'b0, 4'(b - 8'h57)};
    return v;
  endfunction

  // Adds one content byte to the size line; bit 4 of hex_value marks a non-hex byte.
  function automatic line_upd_t line_byte(input line_upd_t cur, input logic [7:0] max_len,
                                          input logic [7:0] b);
    line_upd_t  r;
    logic [8:0] n;
    logic [4:0] v;
    r = cur;
    r.err = ERR_NONE;
    n = {1'b0, cur.line_count} + 9'd1;
    v = hex_value(b);
    if (n > {1'b0, max_len}) begin
      r.err = ERR_LINE_LONG;
    end else begin
      r.line_count = n[7:0];
      if (!cur.digits_ended) begin
        if (v[4]) begin
          r.digits_ended = 1'b1;
        end else if (cur.chunk_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
          r.err = ERR_OVERFLOW;
        end else begin
          r.chunk_remaining = {cur.chunk_remaining[SIZE_BITS-5:0], v[3:0]};
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/hcbd_step.sv
// Next-state and result logic for one word of the chunked body decoder.
`default_nettype none
module hcbd_step (
  input  wire hcbd_pkg::state_t  st,
  input  wire                    op,
  input  wire [7:0]              data_in,
  input  wire [7:0]              max_len,
  output hcbd_pkg::state_t       st_next,
  output hcbd_pkg::result_t      res
);

  hcbd_pkg::line_upd_t lu0;
  hcbd_pkg::line_upd_t lu1;
  hcbd_pkg::line_upd_t lu2;
  hcbd_pkg::err_t      err;

  always_comb begin
    st_next = st;
    res = '0;
    err = hcbd_pkg::ERR_NONE;
    lu0.chunk_remaining = st.chunk_remaining;
    lu0.line_count = st.line_count;
    lu0.digits_ended = st.digits_ended;
    lu0.err = hcbd_pkg::ERR_NONE;
    lu1 = hcbd_pkg::line_byte(lu0, max_len, hcbd_pkg::BYTE_CR);
    lu2 = st.pending_cr ? lu1 : lu0;
    if (op) begin
      st_next = '0;
      st_next.phase = hcbd_pkg::PH_HEADER;
    end else begin
      unique case (st.phase)
        hcbd_pkg::PH_IDLE: begin
          err = hcbd_pkg::ERR_NOT_STARTED;
        end
        hcbd_pkg::PH_HEADER: begin
          if (st.pending_cr && data_in == hcbd_pkg::BYTE_LF) begin
            st_next.pending_cr = 1'b0;
            st_next.line_count = '0;
            st_next.digits_ended = 1'b0;
            st_next.phase = (st.chunk_remaining == '0) ? hcbd_pkg::PH_CR_END
                                                       : hcbd_pkg::PH_BODY;
            res.consumed = 1'b1;
          end else if (st.pending_cr && lu1.err != hcbd_pkg::ERR_NONE) begin
            st_next.pending_cr = 1'b0;
            err = lu1.err;
          end else begin
            st_next.pending_cr = 1'b0;
            if (data_in == hcbd_pkg::BYTE_CR) begin
              st_next.pending_cr = 1'b1;
              st_next.chunk_remaining = lu2.chunk_remaining;
              st_next.line_count = lu2.line_count;
              st_next.digits_ended = lu2.digits_ended;
            end else begin
              lu2 = hcbd_pkg::line_byte(lu2, max_len, data_in);
              st_next.chunk_remaining = lu2.chunk_remaining;
              st_next.line_count = lu2.line_count;
              st_next.digits_ended = lu2.digits_ended;
              err = lu2.err;
            end
            if (err == hcbd_pkg::ERR_NONE) res.consumed = 1'b1;
          end
        end
        hcbd_pkg::PH_BODY: begin
          res.data_out = data_in;
          res.data_valid = 1'b1;
          res.consumed = 1'b1;
          if (st.chunk_remaining != '0) st_next.chunk_remaining = st.chunk_remaining - 1'b1;
          if (st_next.chunk_remaining == '0) st_next.phase = hcbd_pkg::PH_CR;
        end
        hcbd_pkg::PH_CR: begin
          if (data_in == hcbd_pkg::BYTE_CR) begin
            st_next.phase = hcbd_pkg::PH_LF;
            res.consumed = 1'b1;
          end else begin
            err = hcbd_pkg::ERR_NO_CR_DATA;
          end
        end
        hcbd_pkg::PH_LF: begin
          if (data_in == hcbd_pkg::BYTE_LF) begin
            st_next.phase = hcbd_pkg::PH_HEADER;
            res.consumed = 1'b1;
          end else begin
            err = hcbd_pkg::ERR_NO_LF_DATA;
          end
        end
        hcbd_pkg::PH_CR_END: begin
          if (data_in == hcbd_pkg::BYTE_CR) begin
            st_next.phase = hcbd_pkg::PH_LF_END;
            res.consumed = 1'b1;
          end else begin
            err = hcbd_pkg::ERR_NO_CR_END;
          end
        end
        hcbd_pkg::PH_LF_END: begin
          if (data_in == hcbd_pkg::BYTE_LF) begin
            st_next.phase = hcbd_pkg::PH_DONE;
            res.consumed = 1'b1;
            res.done_res = 1'b1;
          end else begin
            err = hcbd_pkg::ERR_NO_LF_END;
          end
        end
        hcbd_pkg::PH_DONE: begin
          res.done_res = 1'b1;
        end
        default: begin
          err = st.sticky_error;
        end
      endcase
      if (err != hcbd_pkg::ERR_NONE) begin
        st_next.sticky_error = err;
        st_next.phase = hcbd_pkg::PH_ERROR;
        res = '0;
        res.error_code = err;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/http_chunked_body_decoder.sv
// Top level of the chunked body decoder: state, configuration and output buffering.
// An accepted word's result is registered in the result register, or in the skid register while the output stalls.
// Throughput: one word per cycle while in_stall is low; in_stall is high while the skid register is full.
// A two-entry output buffer (result register plus skid register) keeps input and output apart.
// Reset clears the decoder to not started, empties the buffer and sets max_header_len to 32.
`default_nettype none
module http_chunked_body_decoder (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [7:0]  cfg_wdata,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        op,
  input  wire [7:0]  data_in,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] data_out,
  output logic       data_valid,
  output logic       consumed,
  output logic       done_res,
  output logic [2:0] error_code
);

  hcbd_pkg::state_t  st;
  hcbd_pkg::state_t  st_next;
  hcbd_pkg::result_t res_next;
  hcbd_pkg::result_t out_res;
  hcbd_pkg::result_t skid_res;
  logic [7:0]        max_header_len;
  logic              skid_valid;
  logic              accept;
  logic              out_take;

  hcbd_step u_step (
    .st      (st),
    .op      (op),
    .data_in (data_in),
    .max_len (max_header_len),
    .st_next (st_next),
    .res     (res_next)
  );

  assign in_stall = skid_valid;
  assign accept = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // The idle phase is encoded as zero, so clearing the whole state leaves the decoder not started.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      max_header_len <= hcbd_pkg::MAX_LEN_RESET;
    end else begin
      if (cfg_we) max_header_len <= cfg_wdata;
      if (accept) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || out_take) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_res <= skid_res;
    end else if (accept) begin
      if (!out_valid || out_take) out_res <= res_next;
      else skid_res <= res_next;
    end
  end

  assign data_out = out_res.data_out;
  assign data_valid = out_res.data_valid;
  assign consumed = out_res.consumed;
  assign done_res = out_res.done_res;
  assign error_code = out_res.error_code;

endmodule
`default_nettype wire
